// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the decode and execute block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: sv/msde_pkg.sv
// Package with the opcodes, function codes and helpers of the decode and execute block.
package msde_pkg;

   // Default depth of the data memory in words.
   localparam int DATA_WORDS_DEFAULT = 256;

   localparam int XLEN   = 32;
   localparam int REG_AW = 5;

   // Byte distance from one instruction to the next.
   localparam logic [XLEN-1:0] PC_STEP = 32'd4;

   // Major opcodes handled by the block.
   typedef enum logic [5:0] {
      OP_RTYPE = 6'd0,
      OP_J     = 6'd2,
      OP_BEQ   = 6'd4,
      OP_ADDI  = 6'd8,
      OP_LW    = 6'd35,
      OP_SW    = 6'd43
   } opcode_type;

   // Function codes of the register-register operations.
   typedef enum logic [5:0] {
      FN_ADD = 6'd32,
      FN_SUB = 6'd34,
      FN_AND = 6'd36,
      FN_OR  = 6'd37,
      FN_XOR = 6'd38,
      FN_NOR = 6'd39,
      FN_SLT = 6'd42
   } funct_type;

   // Side effects of one executed instruction.
   typedef struct packed {
      logic              wb;
      logic              load;
      logic              store;
      logic              illegal;
      logic [REG_AW-1:0] wb_idx;
   } exec_ctrl_type;

   // Sign-extends a 16-bit immediate to the data width.
   function automatic logic [XLEN-1:0] sign_ext16(input logic [15:0] imm);
      return {{(XLEN-16){imm[15]}}, imm};
   endfunction

endpackage

// File: sv/mips_subset_decode_execute.sv
// Top level of the decode and execute block: register file, ALU and data memory.
//
//   Channel   Ports                                        Direction
//   request   req_valid req_stall req_instruction req_pc   in  (req_stall out)
//   response  rsp_valid rsp_stall rsp_alu_result           out (rsp_stall in)
//             rsp_redirect rsp_target rsp_illegal
//
// One word is accepted per clock while not stalled; its response registers as it executes.
// The register file and data memory are synchronous RAMs read at acceptance and in execute;
// writes from the write-back stage are forwarded, so each result is seen by the next word.
// Reset clears control and the register file valid bits (no clearing pass); data memory is
// not cleared. DATA_WORDS must be a power of two.
// A held response stalls the execute stage, which raises req_stall in the same cycle.
module mips_subset_decode_execute
   import msde_pkg::*;
#(
   parameter int DATA_WORDS = DATA_WORDS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [XLEN-1:0] req_instruction,
   input  logic [XLEN-1:0] req_pc,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [XLEN-1:0] rsp_alu_result,
   output logic            rsp_redirect,
   output logic [XLEN-1:0] rsp_target,
   output logic            rsp_illegal
);

`include "assert_macros.svh"

   localparam int DATA_AW  = $clog2(DATA_WORDS);
   localparam int REG_NUM  = 1 << REG_AW;

   // Storage.
   logic [XLEN-1:0]    rf_mem [REG_NUM];
   logic [REG_NUM-1:0] rf_valid_ff, rf_valid_in;
   logic [XLEN-1:0]    dmem [DATA_WORDS];

   // Execute stage.
   logic               s1_valid_ff, s1_valid_in;
   logic [XLEN-1:0]    s1_instr_ff, s1_pc_ff;
   logic [XLEN-1:0]    rs_rdata_ff, rt_rdata_ff;
   logic               rs_known_ff, rt_known_ff;
   logic               fwd_a_vld_ff, fwd_a_vld_in, fwd_b_vld_ff, fwd_b_vld_in;
   logic [XLEN-1:0]    fwd_a_ff, fwd_a_in, fwd_b_ff, fwd_b_in;

   // Write-back stage.
   logic               s2_wb_ff, s2_wb_in;
   logic               s2_load_ff;
   logic [REG_AW-1:0]  s2_idx_ff;
   logic [XLEN-1:0]    s2_alu_ff;
   logic [XLEN-1:0]    dmem_rdata_ff;
   logic [XLEN-1:0]    s2_value;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [XLEN-1:0]    rsp_alu_result_ff, rsp_target_ff;
   logic               rsp_redirect_ff, rsp_illegal_ff;

   // Execute stage logic.
   logic               req_accept, s1_fire;
   logic [REG_AW-1:0]  req_rs, req_rt, s1_rs, s1_rt, s1_rd;
   logic [5:0]         opcode, funct;
   logic [XLEN-1:0]    op_a, op_b, simm, pc4, addend, sum;
   logic               sub_sel, use_rt, less;
   logic [XLEN-1:0]    result, target;
   logic               redirect;
   exec_ctrl_type      ctrl;
   logic [DATA_AW-1:0] dmem_idx;

   // Handshake.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   assign req_rs = req_instruction[25:21];
   assign req_rt = req_instruction[20:16];
   assign s1_rs  = s1_instr_ff[25:21];
   assign s1_rt  = s1_instr_ff[20:16];
   assign s1_rd  = s1_instr_ff[15:11];

   // Value leaving the write-back stage: the load word or the ALU result.
   assign s2_value = s2_load_ff ? dmem_rdata_ff : s2_alu_ff;

   // Operands, newest first: write-back stage, captured write, then the RAM read.
   always_comb begin
      if (s2_wb_ff && (s2_idx_ff == s1_rs)) begin
         op_a = s2_value;
      end else if (fwd_a_vld_ff) begin
         op_a = fwd_a_ff;
      end else begin
         op_a = rs_known_ff ? rs_rdata_ff : '0;
      end
      if (s2_wb_ff && (s2_idx_ff == s1_rt)) begin
         op_b = s2_value;
      end else if (fwd_b_vld_ff) begin
         op_b = fwd_b_ff;
      end else begin
         op_b = rt_known_ff ? rt_rdata_ff : '0;
      end
   end

   // Writes that land after the RAM read was taken are kept for the waiting word.
   always_comb begin
      fwd_a_vld_in = fwd_a_vld_ff;
      fwd_a_in     = fwd_a_ff;
      fwd_b_vld_in = fwd_b_vld_ff;
      fwd_b_in     = fwd_b_ff;
      if (req_accept) begin
         fwd_a_vld_in = s2_wb_ff && (s2_idx_ff == req_rs);
         fwd_a_in     = s2_value;
         fwd_b_vld_in = s2_wb_ff && (s2_idx_ff == req_rt);
         fwd_b_in     = s2_value;
      end else begin
         if (s2_wb_ff && (s2_idx_ff == s1_rs)) begin
            fwd_a_vld_in = 1'b1;
            fwd_a_in     = s2_value;
         end
         if (s2_wb_ff && (s2_idx_ff == s1_rt)) begin
            fwd_b_vld_in = 1'b1;
            fwd_b_in     = s2_value;
         end
      end
   end

   // Shared adder and signed compare.
   always_comb begin
      opcode  = s1_instr_ff[31:26];
      funct   = s1_instr_ff[5:0];
      simm    = sign_ext16(s1_instr_ff[15:0]);
      pc4     = s1_pc_ff + PC_STEP;
      use_rt  = (opcode == OP_RTYPE) || (opcode == OP_BEQ);
      sub_sel = (opcode == OP_BEQ) || ((opcode == OP_RTYPE) && (funct == FN_SUB));
      addend  = use_rt ? op_b : simm;
      sum     = op_a + (sub_sel ? ~addend : addend) + {{(XLEN-1){1'b0}}, sub_sel};
      less    = $signed(op_a) < $signed(op_b);
   end

   // Decode and result selection.
   always_comb begin
      ctrl     = '0;
      result   = '0;
      redirect = 1'b0;
      target   = pc4;
      case (opcode)
         OP_RTYPE: begin
            ctrl.wb     = 1'b1;
            ctrl.wb_idx = s1_rd;
            case (funct)
               FN_ADD:  result = sum;
               FN_SUB:  result = sum;
               FN_AND:  result = op_a & op_b;
               FN_OR:   result = op_a | op_b;
               FN_XOR:  result = op_a ^ op_b;
               FN_NOR:  result = ~(op_a | op_b);
               FN_SLT:  result = {{(XLEN-1){1'b0}}, less};
               default: begin
                  ctrl.wb      = 1'b0;
                  ctrl.illegal = 1'b1;
               end
            endcase
         end
         OP_ADDI: begin
            result      = sum;
            ctrl.wb     = 1'b1;
            ctrl.wb_idx = s1_rt;
         end
         OP_LW: begin
            result      = sum;
            ctrl.wb     = 1'b1;
            ctrl.load   = 1'b1;
            ctrl.wb_idx = s1_rt;
         end
         OP_SW: begin
            result     = sum;
            ctrl.store = 1'b1;
         end
         OP_BEQ: begin
            result = sum;
            if (sum == '0) begin
               redirect = 1'b1;
               target   = pc4 + {simm[XLEN-3:0], 2'b00};
            end
         end
         OP_J: begin
            redirect = 1'b1;
            target   = {pc4[XLEN-1:XLEN-4], s1_instr_ff[25:0], 2'b00};
         end
         default: begin
            ctrl.illegal = 1'b1;
         end
      endcase
      // Register zero is never written.
      if (ctrl.wb_idx == '0) begin
         ctrl.wb = 1'b0;
      end
   end

   assign dmem_idx = result[DATA_AW+1:2];

   // Next values of control state.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      s2_wb_in     = s1_fire && ctrl.wb;
      rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
      rf_valid_in  = rf_valid_ff;
      if (s2_wb_ff) begin
         rf_valid_in[s2_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_wb_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
         fwd_a_vld_ff <= 1'b0;
         fwd_b_vld_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_wb_ff     <= s2_wb_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
         fwd_a_vld_ff <= fwd_a_vld_in;
         fwd_b_vld_ff <= fwd_b_vld_in;
      end
   end

   // Execute stage payload and forwarded operands.
   always_ff @(posedge clock) begin
      fwd_a_ff <= fwd_a_in;
      fwd_b_ff <= fwd_b_in;
      if (req_accept) begin
         s1_instr_ff <= req_instruction;
         s1_pc_ff    <= req_pc;
         rs_known_ff <= rf_valid_ff[req_rs];
         rt_known_ff <= rf_valid_ff[req_rt];
      end
   end

   // Register file RAM: two registered reads at acceptance, one write from write-back.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rs_rdata_ff <= rf_mem[req_rs];
         rt_rdata_ff <= rf_mem[req_rt];
      end
      if (s2_wb_ff) begin
         rf_mem[s2_idx_ff] <= s2_value;
      end
   end

   // Data memory RAM: stores write rt, loads register the addressed word.
   always_ff @(posedge clock) begin
      if (s1_fire && ctrl.store) begin
         dmem[dmem_idx] <= op_b;
      end
      if (s1_fire && ctrl.load) begin
         dmem_rdata_ff <= dmem[dmem_idx];
      end
   end

   // Write-back stage payload.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_idx_ff  <= ctrl.wb_idx;
         s2_load_ff <= ctrl.load;
         s2_alu_ff  <= result;
      end
   end

   // Response register; an illegal word reports no result and no redirect.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_alu_result_ff <= ctrl.illegal ? '0 : result;
         rsp_redirect_ff   <= redirect && !ctrl.illegal;
         rsp_target_ff     <= ctrl.illegal ? pc4 : target;
         rsp_illegal_ff    <= ctrl.illegal;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alu_result = rsp_alu_result_ff;
   assign rsp_redirect   = rsp_redirect_ff;
   assign rsp_target     = rsp_target_ff;
   assign rsp_illegal    = rsp_illegal_ff;

   // Checks on the pipeline control.
   `ASSERT_ALWAYS(a_no_zero_wb, !s2_wb_ff || (s2_idx_ff != '0), "write-back to register zero")
   `ASSERT_ALWAYS(a_rf_zero_invalid, !rf_valid_ff[0], "register zero marked as written")
   `ASSERT_IMPLY(a_stall_cause, req_stall, rsp_valid_ff && rsp_stall, "request stalled without cause")
   `ASSERT_IMPLY(a_wb_after_fire, s2_wb_ff, $past(s1_fire), "write-back without an executed word")
   `ASSERT_IMPLY(a_illegal_quiet, rsp_valid_ff && rsp_illegal_ff, !rsp_redirect_ff, "illegal word redirected")

endmodule
